[hw/rtl/gtp_pkg.sv]
// Package for the group tag policy table: field widths, command and status codes,
// and the packed payload, rule and token types. No dependencies.
`default_nettype none
package gtp_pkg;

    localparam int TAG_W         = 14;
    localparam int IDX_W         = 6;
    localparam int DEF_MAX_RULES = 64;

    localparam logic [1:0] CMD_APPLY = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_DEL   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_NOTFD = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [TAG_W-1:0] src_tag;
        logic [TAG_W-1:0] dst_tag;
        logic             rule_permit;
    } t_in;

    typedef struct packed {
        logic             permit;
        logic             matched;
        logic [IDX_W-1:0] match_index;
        logic [1:0]       status;
    } t_out;

    typedef struct packed {
        logic [TAG_W-1:0] src;
        logic [TAG_W-1:0] dst;
        logic             act;
    } t_rule;

    typedef struct packed {
        logic             vld;
        logic [1:0]       cmd;
        logic [TAG_W-1:0] src;
        logic [TAG_W-1:0] dst;
        logic             act;
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic             hact;
    } t_tok;

endpackage
`default_nettype wire

[hw/rtl/gtp_cell.sv]
// One rule slot of the policy table chain: holds a rule, acts on the passing command token.
// Depends on gtp_pkg.
`default_nettype none
module gtp_cell
    import gtp_pkg::*;
#(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_tok             i_tok,
    input  wire [CNT_W-1:0]  i_rem,
    output t_tok             o_tok,
    output logic [CNT_W-1:0] o_rem,
    input  t_rule            i_nbr,
    output t_rule            o_rule,
    input  wire              i_shift
);

    t_tok             r_tok;
    t_tok             n_tok;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] n_rem;
    t_rule            r_rule;
    logic             r_sh;
    logic             live;
    logic             amatch;
    logic             xmatch;
    logic             hit_here;
    logic             add_here;

    always_comb begin
        live   = (i_rem != '0);
        amatch = ((r_rule.src == '0) || (r_rule.src == i_tok.src)) &&
                 ((r_rule.dst == '0) || (r_rule.dst == i_tok.dst));
        xmatch = (r_rule.src == i_tok.src) && (r_rule.dst == i_tok.dst);
        hit_here = i_tok.vld && live && !i_tok.hit &&
                   (((i_tok.cmd == CMD_APPLY) && amatch) ||
                    ((i_tok.cmd == CMD_DEL) && xmatch));
        add_here = i_tok.vld && !live && !i_tok.hit && (i_tok.cmd == CMD_ADD);
        n_tok = i_tok;
        if (hit_here) begin
            n_tok.hit  = 1'b1;
            n_tok.idx  = IDX_W'(IDX);
            n_tok.hact = r_rule.act;
        end
        if (add_here) begin
            n_tok.hit = 1'b1;
        end
        n_rem = live ? (i_rem - CNT_W'(1)) : i_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (i_tok.vld) begin
            r_sh <= n_tok.hit;
        end
        if (add_here) begin
            r_rule <= '{src: i_tok.src, dst: i_tok.dst, act: i_tok.act};
        end else if (i_shift && r_sh) begin
            r_rule <= i_nbr;
        end
    end

    assign o_tok  = r_tok;
    assign o_rem  = r_rem;
    assign o_rule = r_rule;

endmodule
`default_nettype wire

[hw/rtl/group_tag_policy_table_unit.sv]
// Top level of the group tag policy table: command sequencer, rule count and result register
// around a chain of gtp_cell slots. Depends on gtp_pkg and gtp_cell.
//
// A command is taken when start is high and busy is low. Its token walks the chain of
// MAX_RULES rule cells one cell per cycle. Every command (apply, add, delete, clear) passes
// through r_launch, each cell register and r_done, and raises o_done with o_res for one
// strobe cycle. busy drops in that same cycle, so a new command can be taken at the edge
// that ends the strobe cycle, but not while one is in flight. The result cannot be stalled:
// sample it when o_done is high. Delete closes the gap in the table at the edge that raises
// the strobe. default_permit is written through the cfg channel, which is always ready.
`default_nettype none
module group_tag_policy_table_unit
    import gtp_pkg::*;
#(
    parameter int MAX_RULES = DEF_MAX_RULES
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    output logic busy,
    input  t_in  i_in,
    output logic o_done,
    output t_out o_res,
    input  wire  i_cfg_valid,
    output logic o_cfg_ready,
    input  wire  i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RULES);

    t_tok             tok [0:MAX_RULES];
    logic [CNT_W-1:0] rem [0:MAX_RULES];
    t_rule            rules [0:MAX_RULES-1];

    logic             r_busy;
    logic             r_done;
    t_out             r_res;
    t_out             n_res;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_def;
    t_tok             r_launch;
    logic [CNT_W-1:0] r_rem0;
    logic             accept;
    logic             shift;
    t_tok             last;

    assign accept      = start && !r_busy;
    assign last        = tok[MAX_RULES];
    assign shift       = last.vld && (last.cmd == CMD_DEL) && last.hit;
    assign o_cfg_ready = 1'b1;
    assign busy        = r_busy;
    assign o_done      = r_done;
    assign o_res       = r_res;
    assign tok[0]      = r_launch;
    assign rem[0]      = r_rem0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RULES; gi++) begin : g_cell
            if (gi < MAX_RULES - 1) begin : g_mid
                gtp_cell #(.CNT_W(CNT_W), .IDX(gi)) u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_tok  (tok[gi]),
                    .i_rem  (rem[gi]),
                    .o_tok  (tok[gi+1]),
                    .o_rem  (rem[gi+1]),
                    .i_nbr  (rules[gi+1]),
                    .o_rule (rules[gi]),
                    .i_shift(shift)
                );
            end else begin : g_end
                gtp_cell #(.CNT_W(CNT_W), .IDX(gi)) u_cell (
                    .i_clk  (i_clk),
                    .i_rst_n(i_rst_n),
                    .i_tok  (tok[gi]),
                    .i_rem  (rem[gi]),
                    .o_tok  (tok[gi+1]),
                    .o_rem  (rem[gi+1]),
                    .i_nbr  (rules[gi]),
                    .o_rule (rules[gi]),
                    .i_shift(shift)
                );
            end
        end
    endgenerate

    always_comb begin
        n_res   = '0;
        n_count = r_count;
        unique case (last.cmd)
            CMD_APPLY: begin
                n_res.permit      = last.hit ? last.hact : r_def;
                n_res.matched     = last.hit;
                n_res.match_index = last.hit ? last.idx : '0;
            end
            CMD_ADD: begin
                if (r_count == CNT_MAX) begin
                    n_res.status = STAT_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DEL: begin
                if (last.hit) begin
                    n_res.match_index = last.idx;
                    n_count           = r_count - CNT_W'(1);
                end else begin
                    n_res.status = STAT_NOTFD;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_done       <= 1'b0;
            r_count      <= '0;
            r_def        <= 1'b0;
            r_launch.vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_def <= i_cfg_data;
            end
            r_launch.vld <= accept;
            if (accept) begin
                r_busy          <= 1'b1;
                r_launch.cmd    <= i_in.cmd;
                r_launch.src    <= i_in.src_tag;
                r_launch.dst    <= i_in.dst_tag;
                r_launch.act    <= i_in.rule_permit;
                r_launch.hit    <= 1'b0;
                r_launch.idx    <= '0;
                r_launch.hact   <= 1'b0;
                r_rem0          <= r_count;
            end
            r_done <= last.vld;
            if (last.vld) begin
                r_busy  <= 1'b0;
                r_res   <= n_res;
                r_count <= n_count;
            end
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("result strobe without a command in flight");

    a_busy_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("busy not raised after command transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("rule count above table size");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_res.status == STAT_FULL)) |-> (r_count == CNT_MAX))
        else $error("table full reported below table size");

endmodule
`default_nettype wire

[bench/group_tag_policy_table_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for group_tag_policy_table_unit: directed and random policy table
// commands, each predicted in-bench and checked against the strobed result. Needs gtp_pkg.
module group_tag_policy_table_unit_test;
    import gtp_pkg::*;

    localparam int RULE_SLOTS   = DEF_MAX_RULES;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 2 * RULE_SLOTS + 8;
    localparam int PHASE_ITEMS  = 220;
    localparam int PRINT_CAP    = 50;

    typedef enum logic [1:0] {JOB_CMD, JOB_CFG, JOB_DRAIN} job_kind_e;

    typedef struct packed {
        job_kind_e  kind;
        t_in        req;
        logic       cfg_bit;
        logic [6:0] gap;
    } job_t;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic start       = 1'b0;
    t_in  i_in        = '0;
    logic i_cfg_valid = 1'b0;
    logic i_cfg_data  = 1'b0;
    logic busy;
    logic o_done;
    t_out o_res;
    logic o_cfg_ready;

    job_t job_q[$];
    t_out verdict_q[$];

    logic [TAG_W-1:0] rule_src_m [RULE_SLOTS];
    logic [TAG_W-1:0] rule_dst_m [RULE_SLOTS];
    logic             rule_act_m [RULE_SLOTS];
    int               rule_cnt    = 0;
    logic             dflt_permit = 1'b0;

    int in_flight   = 0;
    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int result_cnt  = 0;
    int queued_cnt  = 0;
    int sender_gap  = 0;

    logic [TAG_W-1:0] deep_src [RULE_SLOTS+2];
    logic [TAG_W-1:0] deep_dst [RULE_SLOTS+2];

    group_tag_policy_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    task automatic flag_error(input string what);
        if (err_cnt < PRINT_CAP) begin
            $display("ERROR cycle %0d: %s", cycle_cnt, what);
        end
        err_cnt++;
    endtask

    task automatic predict_verdict(input t_in req);
        t_out v;
        int   hit;
        v   = '0;
        hit = -1;
        case (req.cmd)
            CMD_APPLY: begin
                for (int k = 0; k < rule_cnt && hit < 0; k++) begin
                    if ((rule_src_m[k] == '0 || rule_src_m[k] == req.src_tag) &&
                        (rule_dst_m[k] == '0 || rule_dst_m[k] == req.dst_tag)) begin
                        hit = k;
                    end
                end
                if (hit >= 0) begin
                    v.permit      = rule_act_m[hit];
                    v.matched     = 1'b1;
                    v.match_index = hit[IDX_W-1:0];
                end else begin
                    v.permit = dflt_permit;
                end
            end
            CMD_ADD: begin
                if (rule_cnt >= RULE_SLOTS) begin
                    v.status = STAT_FULL;
                end else begin
                    rule_src_m[rule_cnt] = req.src_tag;
                    rule_dst_m[rule_cnt] = req.dst_tag;
                    rule_act_m[rule_cnt] = req.rule_permit;
                    rule_cnt++;
                end
            end
            CMD_DEL: begin
                for (int k = 0; k < rule_cnt && hit < 0; k++) begin
                    if (rule_src_m[k] == req.src_tag && rule_dst_m[k] == req.dst_tag) begin
                        hit = k;
                    end
                end
                if (hit >= 0) begin
                    for (int k = hit; k + 1 < rule_cnt; k++) begin
                        rule_src_m[k] = rule_src_m[k+1];
                        rule_dst_m[k] = rule_dst_m[k+1];
                        rule_act_m[k] = rule_act_m[k+1];
                    end
                    rule_cnt--;
                    v.match_index = hit[IDX_W-1:0];
                end else begin
                    v.status = STAT_NOTFD;
                end
            end
            default: rule_cnt = 0;
        endcase
        verdict_q.push_back(v);
    endtask

    task automatic queue_cmd(input logic [1:0] c, input logic [TAG_W-1:0] s,
                             input logic [TAG_W-1:0] d, input logic a);
        job_t j;
        j             = '0;
        j.kind        = JOB_CMD;
        j.req.cmd     = c;
        j.req.src_tag = s;
        j.req.dst_tag = d;
        j.req.rule_permit = a;
        j.gap         = sender_gap[6:0];
        job_q.push_back(j);
        queued_cnt++;
    endtask

    task automatic queue_marker(input job_kind_e kind, input logic bit_val);
        job_t j;
        j         = '0;
        j.kind    = kind;
        j.cfg_bit = bit_val;
        job_q.push_back(j);
    endtask

    function automatic logic [TAG_W-1:0] pick_tag(input logic wide);
        logic [TAG_W-1:0] t;
        if (wide || $urandom_range(99, 0) < 8) begin
            t = TAG_W'($urandom_range(16383, 0));
        end else begin
            case ($urandom_range(5, 0))
                0:       t = '0;
                1:       t = 14'd1;
                2:       t = 14'd2;
                3:       t = 14'h3FFF;
                4:       t = 14'h2AAA;
                default: t = 14'h1555;
            endcase
        end
        return t;
    endfunction

    always @(posedge i_clk) begin : drive
        logic nxt_start;
        logic nxt_cfg;
        int   live;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            in_flight   <= 0;
        end else begin
            nxt_start = start;
            nxt_cfg   = i_cfg_valid;
            live      = in_flight;
            if (o_done && live > 0) begin
                live--;
            end
            if (start && !busy) begin
                predict_verdict(i_in);
                live++;
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                dflt_permit = i_cfg_data;
                nxt_cfg     = 1'b0;
            end
            if (!nxt_start && !nxt_cfg && job_q.size() > 0) begin
                case (job_q[0].kind)
                    JOB_CMD: begin
                        if ($urandom_range(99, 0) >= job_q[0].gap) begin
                            i_in      <= job_q[0].req;
                            nxt_start = 1'b1;
                            void'(job_q.pop_front());
                        end
                    end
                    JOB_CFG: begin
                        if (live == 0) begin
                            i_cfg_data <= job_q[0].cfg_bit;
                            nxt_cfg    = 1'b1;
                            void'(job_q.pop_front());
                        end
                    end
                    default: begin
                        if (live == 0) begin
                            void'(job_q.pop_front());
                        end
                    end
                endcase
            end
            start       <= nxt_start;
            i_cfg_valid <= nxt_cfg;
            in_flight   <= live;
        end
    end

    always @(posedge i_clk) begin : observe
        t_out want;
        if (i_rst_n && o_done) begin
            result_cnt++;
            if (verdict_q.size() == 0) begin
                flag_error($sformatf("result %0d with no command outstanding", result_cnt));
            end else begin
                want = verdict_q.pop_front();
                if (o_res.permit !== want.permit)
                    flag_error($sformatf("result %0d permit %b, want %b",
                                         result_cnt, o_res.permit, want.permit));
                if (o_res.matched !== want.matched)
                    flag_error($sformatf("result %0d matched %b, want %b",
                                         result_cnt, o_res.matched, want.matched));
                if (o_res.match_index !== want.match_index)
                    flag_error($sformatf("result %0d match_index %0d, want %0d",
                                         result_cnt, o_res.match_index, want.match_index));
                if (o_res.status !== want.status)
                    flag_error($sformatf("result %0d status %0d, want %0d",
                                         result_cnt, o_res.status, want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("group_tag_policy_table_unit_test NOT OK");
            $finish;
        end
    end

    initial begin
        int          seg;
        int          len;
        int          roll;
        int          pick;
        int          phase_base;
        logic        wide;
        logic [1:0]  c;

        sender_gap = 7;
        queue_marker(JOB_CFG, 1'b0);
        queue_cmd(CMD_APPLY, 14'd0, 14'd0, 1'b1);
        queue_cmd(CMD_DEL,   14'd5, 14'd5, 1'b0);
        queue_cmd(CMD_ADD,   14'h3FFF, 14'h3FFF, 1'b1);
        queue_cmd(CMD_ADD,   14'd0, 14'd7, 1'b0);
        queue_cmd(CMD_ADD,   14'd3, 14'd0, 1'b1);
        queue_cmd(CMD_ADD,   14'd0, 14'd0, 1'b1);
        queue_cmd(CMD_APPLY, 14'h3FFF, 14'h3FFF, 1'b0);
        queue_cmd(CMD_APPLY, 14'd9, 14'd7, 1'b0);
        queue_cmd(CMD_APPLY, 14'd3, 14'd100, 1'b0);
        queue_cmd(CMD_APPLY, 14'd0, 14'd0, 1'b0);
        queue_cmd(CMD_APPLY, 14'd0, 14'd7, 1'b0);
        queue_cmd(CMD_DEL,   14'd0, 14'd7, 1'b0);
        queue_cmd(CMD_DEL,   14'd0, 14'd5, 1'b0);
        queue_cmd(CMD_APPLY, 14'd9, 14'd7, 1'b0);
        queue_cmd(CMD_DEL,   14'h3FFF, 14'h3FFF, 1'b0);
        queue_cmd(CMD_CLEAR, 14'h3FFF, 14'h3FFF, 1'b1);
        queue_cmd(CMD_APPLY, 14'd1, 14'd1, 1'b1);
        queue_cmd(CMD_ADD,   14'h2AAA, 14'h1555, 1'b0);
        queue_cmd(CMD_ADD,   14'h1555, 14'h2AAA, 1'b1);
        queue_cmd(CMD_APPLY, 14'h2AAA, 14'h1555, 1'b0);
        queue_cmd(CMD_APPLY, 14'h1555, 14'h2AAA, 1'b0);
        queue_cmd(CMD_APPLY, 14'd1, 14'd2, 1'b0);
        queue_marker(JOB_CFG, 1'b1);
        queue_cmd(CMD_APPLY, 14'd1, 14'd2, 1'b0);
        queue_cmd(CMD_CLEAR, 14'd0, 14'd0, 1'b0);

        for (int phase = 0; phase < 3; phase++) begin
            sender_gap = (phase == 0) ? 7 : (phase == 1) ? 60 : 0;
            phase_base = queued_cnt;
            queue_marker(JOB_CFG, (phase == 1) ? 1'b0 : 1'b1);

            queue_cmd(CMD_CLEAR, pick_tag(1'b1), pick_tag(1'b1), 1'($urandom_range(1, 0)));
            for (int k = 0; k < RULE_SLOTS + 2; k++) begin
                deep_src[k] = TAG_W'($urandom_range(16383, 1));
                deep_dst[k] = TAG_W'($urandom_range(16383, 1));
                queue_cmd(CMD_ADD, deep_src[k], deep_dst[k], 1'($urandom_range(1, 0)));
            end
            for (int k = 0; k < 48; k++) begin
                pick = $urandom_range(RULE_SLOTS - 1, 0);
                c    = (k >= 30 && k < 38) ? CMD_DEL : CMD_APPLY;
                queue_cmd(c, deep_src[pick], deep_dst[pick], 1'($urandom_range(1, 0)));
            end
            queue_cmd(CMD_ADD, pick_tag(1'b1), pick_tag(1'b1), 1'($urandom_range(1, 0)));
            queue_marker(JOB_DRAIN, 1'b0);

            while (queued_cnt - phase_base < PHASE_ITEMS) begin
                seg = $urandom_range(9, 0);
                len = $urandom_range(60, 20);
                for (int k = 0; k < len; k++) begin
                    roll = $urandom_range(99, 0);
                    wide = (seg == 9) && $urandom_range(1, 0);
                    if (seg < 4)
                        c = (roll < 70) ? CMD_ADD : (roll < 95) ? CMD_APPLY : CMD_DEL;
                    else if (seg < 7)
                        c = (roll < 70) ? CMD_APPLY : (roll < 85) ? CMD_ADD : CMD_DEL;
                    else if (seg < 9)
                        c = (roll < 40) ? CMD_DEL : (roll < 80) ? CMD_ADD : CMD_APPLY;
                    else
                        c = 2'($urandom_range(3, 0));
                    queue_cmd(c, pick_tag(wide), pick_tag(wide), 1'($urandom_range(1, 0)));
                end
                if ($urandom_range(99, 0) < 15)
                    queue_cmd(CMD_CLEAR, pick_tag(1'b0), pick_tag(1'b0),
                              1'($urandom_range(1, 0)));
                if ($urandom_range(99, 0) < 10)
                    queue_marker(JOB_DRAIN, 1'b0);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (job_q.size() == 0 && !start && !i_cfg_valid && in_flight == 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (verdict_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", verdict_q.size()));
        if (err_cnt == 0) begin
            $display("group_tag_policy_table_unit_test OK");
        end else begin
            $display("group_tag_policy_table_unit_test NOT OK");
        end
        $finish;
    end

endmodule
